FILE: design/utf8_source_tokenizer_defines.svh
// Assertion macros for the UTF-8 source tokenizer.
`ifndef UTF8_SOURCE_TOKENIZER_DEFINES_SVH
`define UTF8_SOURCE_TOKENIZER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define UST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8_source_tokenizer: assertion failed");

// Consequence in the cycle after the condition.
`define UST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8_source_tokenizer: assertion failed");

`endif

FILE: design/utf8st_pkg.sv
// Shared types, token codes and byte classifiers for the UTF-8 source tokenizer.
`default_nettype none

package utf8st_pkg;

    localparam int OFFSET_BITS_DEF    = 24;
    localparam int POSITION_BITS_DEF  = 16;
    localparam int MAX_OPERATOR_BYTES = 3;
    localparam int QUEUE_DEPTH        = 4;
    localparam int LEN_BITS           = 16;

    localparam logic [5:0] K_VAR        = 6'd0;
    localparam logic [5:0] K_CONST      = 6'd1;
    localparam logic [5:0] K_FUNC       = 6'd2;
    localparam logic [5:0] K_RETURN     = 6'd3;
    localparam logic [5:0] K_IF         = 6'd4;
    localparam logic [5:0] K_ELIF       = 6'd5;
    localparam logic [5:0] K_ELSE       = 6'd6;
    localparam logic [5:0] K_FOR        = 6'd7;
    localparam logic [5:0] K_WHILE      = 6'd8;
    localparam logic [5:0] K_BREAK      = 6'd9;
    localparam logic [5:0] K_CONTINUE   = 6'd10;
    localparam logic [5:0] K_IMPORT     = 6'd11;
    localparam logic [5:0] K_EXPORT     = 6'd12;
    localparam logic [5:0] K_STRUCT     = 6'd13;
    localparam logic [5:0] K_UNION      = 6'd14;
    localparam logic [5:0] K_BOOL       = 6'd15;
    localparam logic [5:0] K_NULL       = 6'd16;
    localparam logic [5:0] K_IDENT      = 6'd17;
    localparam logic [5:0] K_NUMBER     = 6'd18;
    localparam logic [5:0] K_STRING     = 6'd19;
    localparam logic [5:0] K_CHAR       = 6'd20;
    localparam logic [5:0] K_PLUS       = 6'd21;
    localparam logic [5:0] K_MINUS      = 6'd22;
    localparam logic [5:0] K_STAR       = 6'd23;
    localparam logic [5:0] K_SLASH      = 6'd24;
    localparam logic [5:0] K_PERCENT    = 6'd25;
    localparam logic [5:0] K_POWER      = 6'd26;
    localparam logic [5:0] K_EQ         = 6'd27;
    localparam logic [5:0] K_NE         = 6'd28;
    localparam logic [5:0] K_GT         = 6'd29;
    localparam logic [5:0] K_LT         = 6'd30;
    localparam logic [5:0] K_GE         = 6'd31;
    localparam logic [5:0] K_LE         = 6'd32;
    localparam logic [5:0] K_AND        = 6'd33;
    localparam logic [5:0] K_OR         = 6'd34;
    localparam logic [5:0] K_NOT        = 6'd35;
    localparam logic [5:0] K_ASSIGN     = 6'd36;
    localparam logic [5:0] K_ADD_ASSIGN = 6'd37;
    localparam logic [5:0] K_SUB_ASSIGN = 6'd38;
    localparam logic [5:0] K_MUL_ASSIGN = 6'd39;
    localparam logic [5:0] K_DIV_ASSIGN = 6'd40;
    localparam logic [5:0] K_MOD_ASSIGN = 6'd41;
    localparam logic [5:0] K_LPAREN     = 6'd42;
    localparam logic [5:0] K_RPAREN     = 6'd43;
    localparam logic [5:0] K_LBRACKET   = 6'd44;
    localparam logic [5:0] K_RBRACKET   = 6'd45;
    localparam logic [5:0] K_LBRACE     = 6'd46;
    localparam logic [5:0] K_RBRACE     = 6'd47;
    localparam logic [5:0] K_COMMA      = 6'd48;
    localparam logic [5:0] K_SEMI       = 6'd49;
    localparam logic [5:0] K_COLON      = 6'd50;
    localparam logic [5:0] K_ARROW      = 6'd51;
    localparam logic [5:0] K_ELLIPSIS   = 6'd52;
    localparam logic [5:0] K_DOT        = 6'd53;
    localparam logic [5:0] K_END        = 6'd54;
    localparam logic [5:0] K_ERROR      = 6'd55;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_OPEN_STR   = 3'd1;
    localparam logic [2:0] E_OPEN_CHAR  = 3'd2;
    localparam logic [2:0] E_EMPTY_CHAR = 3'd3;
    localparam logic [2:0] E_LONG_CHAR  = 3'd4;
    localparam logic [2:0] E_ILLEGAL    = 3'd5;

    typedef struct packed {
        logic [1:0] len;
        logic [5:0] kind;
    } t_punct;

    typedef struct packed {
        logic draining;
        logic hold_valid;
    } t_front_stat;

    function automatic int data_bits(input int ob, input int pb);
        return ((6 + 3 + ob + LEN_BITS + 2 * pb + 7) / 8) * 8;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic logic is_ideograph(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2);
        return (b0 >= 8'hE4) && (b0 <= 8'hE9) && (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10)
            && !(b0 == 8'hE4 && b1 < 8'hB8);
    endfunction

    function automatic logic [5:0] word_kind(input logic [5:0][7:0] w,
                                             input logic [LEN_BITS-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len == LEN_BITS'(3)) begin
            unique case ({w[0], w[1], w[2]})
                24'hE4BBA4: k = K_VAR;
                24'hE68192: k = K_CONST;
                24'hE587BD: k = K_FUNC;
                24'hE8BF94: k = K_RETURN;
                24'hE88BA5: k = K_IF;
                24'hE4BAA6: k = K_ELIF;
                24'hE58899: k = K_ELSE;
                24'hE9818D: k = K_FOR;
                24'hE5BD93: k = K_WHILE;
                24'hE692A4: k = K_BREAK;
                24'hE8BF87: k = K_CONTINUE;
                24'hE7BB84: k = K_STRUCT;
                24'hE59BA2: k = K_UNION;
                24'hE79C9F: k = K_BOOL;
                24'hE58187: k = K_BOOL;
                24'hE7A9BA: k = K_NULL;
                default:    k = K_IDENT;
            endcase
        end else if (len == LEN_BITS'(6)) begin
            unique case ({w[0], w[1], w[2], w[3], w[4], w[5]})
                48'hE5AFBCE585A5: k = K_IMPORT;
                48'hE5AFBCE587BA: k = K_EXPORT;
                default:          k = K_IDENT;
            endcase
        end
        return k;
    endfunction

    function automatic t_punct punct_match(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [1:0] cnt);
        t_punct r;
        r = '{len: 2'd0, kind: K_ERROR};
        if (cnt == 2'd3) begin
            unique case ({b0, b1, b2})
                "...":      r = '{len: 2'd3, kind: K_ELLIPSIS};
                24'hEFBC81: r = '{len: 2'd3, kind: K_NOT};
                24'hEFBC88: r = '{len: 2'd3, kind: K_LPAREN};
                24'hEFBC89: r = '{len: 2'd3, kind: K_RPAREN};
                24'hEFBC8C: r = '{len: 2'd3, kind: K_COMMA};
                24'hEFBC9B: r = '{len: 2'd3, kind: K_SEMI};
                24'hEFBC9A: r = '{len: 2'd3, kind: K_COLON};
                default:    r = '{len: 2'd0, kind: K_ERROR};
            endcase
        end
        if (r.len == 2'd0 && cnt >= 2'd2) begin
            unique case ({b0, b1})
                "**":    r = '{len: 2'd2, kind: K_POWER};
                "==":    r = '{len: 2'd2, kind: K_EQ};
                "!=":    r = '{len: 2'd2, kind: K_NE};
                ">=":    r = '{len: 2'd2, kind: K_GE};
                "<=":    r = '{len: 2'd2, kind: K_LE};
                "&&":    r = '{len: 2'd2, kind: K_AND};
                "||":    r = '{len: 2'd2, kind: K_OR};
                "+=":    r = '{len: 2'd2, kind: K_ADD_ASSIGN};
                "-=":    r = '{len: 2'd2, kind: K_SUB_ASSIGN};
                "*=":    r = '{len: 2'd2, kind: K_MUL_ASSIGN};
                "/=":    r = '{len: 2'd2, kind: K_DIV_ASSIGN};
                "%=":    r = '{len: 2'd2, kind: K_MOD_ASSIGN};
                "=>":    r = '{len: 2'd2, kind: K_ARROW};
                default: r = '{len: 2'd0, kind: K_ERROR};
            endcase
        end
        if (r.len == 2'd0 && cnt >= 2'd1) begin
            unique case (b0)
                "+":     r = '{len: 2'd1, kind: K_PLUS};
                "-":     r = '{len: 2'd1, kind: K_MINUS};
                "*":     r = '{len: 2'd1, kind: K_STAR};
                "/":     r = '{len: 2'd1, kind: K_SLASH};
                "%":     r = '{len: 2'd1, kind: K_PERCENT};
                ">":     r = '{len: 2'd1, kind: K_GT};
                "<":     r = '{len: 2'd1, kind: K_LT};
                "!":     r = '{len: 2'd1, kind: K_NOT};
                "=":     r = '{len: 2'd1, kind: K_ASSIGN};
                "(":     r = '{len: 2'd1, kind: K_LPAREN};
                ")":     r = '{len: 2'd1, kind: K_RPAREN};
                "[":     r = '{len: 2'd1, kind: K_LBRACKET};
                "]":     r = '{len: 2'd1, kind: K_RBRACKET};
                "{":     r = '{len: 2'd1, kind: K_LBRACE};
                "}":     r = '{len: 2'd1, kind: K_RBRACE};
                ",":     r = '{len: 2'd1, kind: K_COMMA};
                ";":     r = '{len: 2'd1, kind: K_SEMI};
                ":":     r = '{len: 2'd1, kind: K_COLON};
                ".":     r = '{len: 2'd1, kind: K_DOT};
                default: r = '{len: 2'd0, kind: K_ERROR};
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/utf8st_tokq.sv
// Short register queue of finished tokens between the lexer and the output port.
`default_nettype none

module utf8st_tokq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = utf8st_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_count, n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (i_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/utf8st_front.sv
// Lexer front end: lookahead window, position tracking, one step per unstalled cycle.
`default_nettype none

module utf8st_front #(
    parameter int OFFSET_BITS   = utf8st_pkg::OFFSET_BITS_DEF,
    parameter int POSITION_BITS = utf8st_pkg::POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_end,
    output logic                          o_ready,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output logic [utf8st_pkg::data_bits(OFFSET_BITS, POSITION_BITS)-1:0] o_push_data,
    output logic                          o_push_last,
    output utf8st_pkg::t_front_stat       o_stat
);

    localparam int DB = utf8st_pkg::data_bits(OFFSET_BITS, POSITION_BITS);
    localparam int WN = utf8st_pkg::MAX_OPERATOR_BYTES;
    localparam int LB = utf8st_pkg::LEN_BITS;
    localparam int OB = OFFSET_BITS;
    localparam int PB = POSITION_BITS;

    localparam logic [2:0] M_IDLE      = 3'd0;
    localparam logic [2:0] M_IDENT     = 3'd1;
    localparam logic [2:0] M_NUMBER    = 3'd2;
    localparam logic [2:0] M_STRING    = 3'd3;
    localparam logic [2:0] M_CHAR_OPEN = 3'd4;
    localparam logic [2:0] M_CHAR_ESC  = 3'd5;
    localparam logic [2:0] M_CHAR_BODY = 3'd6;

    logic [2:0]         r_mode, n_mode;
    logic [WN-1:0][7:0] r_win, n_win;
    logic [1:0]         r_cnt, n_cnt;
    logic [5:0][7:0]    r_word;
    logic               r_esc, n_esc, r_dot, n_dot, r_drain, n_drain, r_hold_v, n_hold_v;
    logic [DB-1:0]      r_hold, n_hold;
    logic [LB-1:0]      r_tok_len, n_tok_len;
    logic [OB-1:0]      r_tstart, n_tstart, r_off, n_off;
    logic [PB-1:0]      r_sline, n_sline, r_scol, n_scol, r_line, n_line, r_col, n_col;

    logic [1:0] d_cons, d_plen, d_add, d_store;
    logic       d_emit, d_end, d_pend, d_mark, d_dot, d_esc;
    logic [5:0] d_kind;
    logic [2:0] d_err, d_mode;

    logic [7:0]          b0, b1, b2;
    logic                w_ideo, w_active, w_finish, w_can, w_blocked, w_fire, w_acc;
    utf8st_pkg::t_punct  w_punct;
    logic [DB-1:0]       w_new;
    logic [2:0]          w_tl;
    logic [LB:0]         w_len_sum;
    logic [PB:0]         w_col_sum;
    logic [1:0]          w_cnt_sh;

    assign b0       = r_win[0];
    assign b1       = r_win[1];
    assign b2       = r_win[2];
    assign w_ideo   = (r_cnt == 2'd3) && utf8st_pkg::is_ideograph(b0, b1, b2);
    assign w_punct  = utf8st_pkg::punct_match(b0, b1, b2, r_cnt);
    assign w_active = (r_cnt == 2'd3) || (r_drain && r_cnt != 2'd0);
    assign w_finish = r_drain && (r_cnt == 2'd0);
    assign w_tl     = r_tok_len[2:0];

    always_comb begin
        d_cons  = 2'd0;
        d_plen  = 2'd0;
        d_add   = 2'd0;
        d_store = 2'd0;
        d_emit  = 1'b0;
        d_end   = 1'b0;
        d_pend  = 1'b0;
        d_mark  = 1'b0;
        d_dot   = r_dot;
        d_esc   = r_esc;
        d_kind  = utf8st_pkg::K_ERROR;
        d_err   = utf8st_pkg::E_NONE;
        d_mode  = r_mode;
        if (w_active) begin
            unique case (r_mode)
                M_IDLE: begin
                    if (utf8st_pkg::is_space(b0)) begin
                        d_cons = 2'd1;
                    end else if (utf8st_pkg::is_letter(b0) || w_ideo) begin
                        d_mark = 1'b1;
                        d_mode = M_IDENT;
                    end else if (utf8st_pkg::is_digit(b0)) begin
                        d_mark = 1'b1;
                        d_dot  = 1'b0;
                        d_mode = M_NUMBER;
                    end else if (b0 == "\"") begin
                        d_cons = 2'd1;
                        d_mark = 1'b1;
                        d_esc  = 1'b0;
                        d_mode = M_STRING;
                    end else if (b0 == "'") begin
                        d_cons = 2'd1;
                        d_mark = 1'b1;
                        d_mode = M_CHAR_OPEN;
                    end else if (w_punct.len != 2'd0) begin
                        d_emit = 1'b1;
                        d_kind = w_punct.kind;
                        d_plen = w_punct.len;
                        d_cons = w_punct.len;
                    end else begin
                        d_emit = 1'b1;
                        d_kind = utf8st_pkg::K_ERROR;
                        d_err  = utf8st_pkg::E_ILLEGAL;
                        d_plen = 2'd1;
                        d_cons = 2'd1;
                    end
                end
                M_IDENT: begin
                    if (utf8st_pkg::is_letter(b0) || utf8st_pkg::is_digit(b0)) begin
                        d_store = 2'd1;
                        d_add   = 2'd1;
                        d_cons  = 2'd1;
                    end else if (w_ideo) begin
                        d_store = 2'd3;
                        d_add   = 2'd3;
                        d_cons  = 2'd3;
                    end else begin
                        d_emit = 1'b1;
                        d_pend = 1'b1;
                        d_kind = utf8st_pkg::word_kind(r_word, r_tok_len);
                        d_mode = M_IDLE;
                    end
                end
                M_NUMBER: begin
                    if (utf8st_pkg::is_digit(b0)) begin
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                    end else if (b0 == "." && !r_dot && r_cnt >= 2'd2
                                 && utf8st_pkg::is_digit(b1)) begin
                        d_dot  = 1'b1;
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                    end else begin
                        d_emit = 1'b1;
                        d_pend = 1'b1;
                        d_kind = utf8st_pkg::K_NUMBER;
                        d_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (b0 == "\"" && !r_esc) begin
                        d_cons = 2'd1;
                        d_emit = 1'b1;
                        d_pend = 1'b1;
                        d_kind = utf8st_pkg::K_STRING;
                        d_mode = M_IDLE;
                    end else begin
                        d_esc  = (b0 == "\\") ? !r_esc : 1'b0;
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                    end
                end
                M_CHAR_OPEN: begin
                    if (b0 == "\\") begin
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                        d_mode = M_CHAR_ESC;
                    end else if (b0 == "'") begin
                        d_emit = 1'b1;
                        d_pend = 1'b1;
                        d_err  = utf8st_pkg::E_EMPTY_CHAR;
                        d_mode = M_IDLE;
                    end else begin
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                        d_mode = M_CHAR_BODY;
                    end
                end
                M_CHAR_ESC: begin
                    if (b0 == "'") begin
                        d_emit = 1'b1;
                        d_pend = 1'b1;
                        d_err  = utf8st_pkg::E_EMPTY_CHAR;
                        d_mode = M_IDLE;
                    end else begin
                        d_add  = 2'd1;
                        d_cons = 2'd1;
                        d_mode = M_CHAR_BODY;
                    end
                end
                M_CHAR_BODY: begin
                    d_emit = 1'b1;
                    d_pend = 1'b1;
                    d_mode = M_IDLE;
                    if (b0 == "'") begin
                        d_cons = 2'd1;
                        d_kind = utf8st_pkg::K_CHAR;
                    end else begin
                        d_err = utf8st_pkg::E_LONG_CHAR;
                    end
                end
                default: begin
                    d_mode = M_IDLE;
                end
            endcase
        end else if (w_finish) begin
            d_emit = 1'b1;
            d_pend = 1'b1;
            d_mode = M_IDLE;
            unique case (r_mode)
                M_IDENT:     d_kind = utf8st_pkg::word_kind(r_word, r_tok_len);
                M_NUMBER:    d_kind = utf8st_pkg::K_NUMBER;
                M_STRING:    d_err  = utf8st_pkg::E_OPEN_STR;
                M_CHAR_OPEN: d_err  = utf8st_pkg::E_OPEN_CHAR;
                M_CHAR_ESC,
                M_CHAR_BODY: d_err  = utf8st_pkg::E_LONG_CHAR;
                default: begin
                    d_pend = 1'b0;
                    d_end  = 1'b1;
                    d_kind = utf8st_pkg::K_END;
                end
            endcase
        end
    end

    always_comb begin
        if (d_pend) begin
            w_new = DB'({r_scol, r_sline, r_tok_len, r_tstart, d_err, d_kind});
        end else begin
            w_new = DB'({r_col, r_line, LB'(d_plen), r_off, d_err, d_kind});
        end
    end

    // A token whose last transfer is not yet known waits in the hold register.
    assign w_can     = (w_active || w_finish) && !i_q_full;
    assign w_blocked = r_hold_v && d_emit;
    assign w_fire    = w_can && !w_blocked;
    assign o_ready   = !r_drain && ((r_cnt != 2'd3) || (w_fire && d_cons != 2'd0));
    assign w_acc     = i_valid && o_ready;
    assign o_stat    = '{draining: r_drain, hold_valid: r_hold_v};

    always_comb begin
        o_push      = 1'b0;
        o_push_data = w_new;
        o_push_last = 1'b0;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        if (w_can && w_blocked) begin
            o_push      = 1'b1;
            o_push_data = r_hold;
            n_hold_v    = 1'b0;
        end else if (w_fire) begin
            if (r_drain) begin
                o_push      = d_emit;
                o_push_last = d_end;
            end else if (d_emit && d_cons != 2'd0) begin
                o_push      = 1'b1;
                o_push_last = 1'b1;
            end else if (d_emit) begin
                n_hold_v = 1'b1;
                n_hold   = w_new;
            end else if (d_cons != 2'd0 && r_hold_v) begin
                o_push      = 1'b1;
                o_push_data = r_hold;
                o_push_last = 1'b1;
                n_hold_v    = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_win     = r_win;
        n_cnt     = r_cnt;
        n_esc     = r_esc;
        n_dot     = r_dot;
        n_drain   = r_drain;
        n_tok_len = r_tok_len;
        n_tstart  = r_tstart;
        n_sline   = r_sline;
        n_scol    = r_scol;
        n_line    = r_line;
        n_col     = r_col;
        n_off     = r_off;
        w_len_sum = {1'b0, r_tok_len} + (LB + 1)'(d_add);
        w_col_sum = {1'b0, r_col} + (PB + 1)'(d_cons);
        w_cnt_sh  = r_cnt;
        if (w_fire) begin
            w_cnt_sh = r_cnt - d_cons;
            case (d_cons)
                2'd1:    n_win = {8'h00, r_win[2], r_win[1]};
                2'd2:    n_win = {8'h00, 8'h00, r_win[2]};
                2'd3:    n_win = '0;
                default: n_win = r_win;
            endcase
            if (d_cons != 2'd0) begin
                n_off = r_off + OB'(d_cons);
                if (d_cons == 2'd1 && b0 == 8'h0A) begin
                    n_line = (r_line != '1) ? r_line + PB'(1) : r_line;
                    n_col  = PB'(1);
                end else begin
                    n_col = w_col_sum[PB] ? '1 : w_col_sum[PB-1:0];
                end
            end
            n_mode = d_mode;
            n_dot  = d_dot;
            n_esc  = d_esc;
            if (d_mark) begin
                n_tstart  = n_off;
                n_sline   = n_line;
                n_scol    = n_col;
                n_tok_len = '0;
            end else begin
                n_tok_len = w_len_sum[LB] ? '1 : w_len_sum[LB-1:0];
            end
            if (d_end) begin
                n_mode    = M_IDLE;
                n_cnt     = 2'd0;
                n_esc     = 1'b0;
                n_dot     = 1'b0;
                n_drain   = 1'b0;
                n_tok_len = '0;
                n_tstart  = '0;
                n_sline   = PB'(1);
                n_scol    = PB'(1);
                n_line    = PB'(1);
                n_col     = PB'(1);
                n_off     = '0;
            end else begin
                n_cnt = w_cnt_sh;
            end
        end
        if (w_acc) begin
            if (i_end) begin
                n_drain = 1'b1;
            end else begin
                n_win[w_cnt_sh] = i_byte;
                n_cnt           = w_cnt_sh + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_cnt     <= 2'd0;
            r_esc     <= 1'b0;
            r_dot     <= 1'b0;
            r_drain   <= 1'b0;
            r_hold_v  <= 1'b0;
            r_tok_len <= '0;
            r_tstart  <= '0;
            r_sline   <= PB'(1);
            r_scol    <= PB'(1);
            r_line    <= PB'(1);
            r_col     <= PB'(1);
            r_off     <= '0;
        end else begin
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_esc     <= n_esc;
            r_dot     <= n_dot;
            r_drain   <= n_drain;
            r_hold_v  <= n_hold_v;
            r_tok_len <= n_tok_len;
            r_tstart  <= n_tstart;
            r_sline   <= n_sline;
            r_scol    <= n_scol;
            r_line    <= n_line;
            r_col     <= n_col;
            r_off     <= n_off;
        end
    end

    // The first six bytes of an identifier are kept for keyword matching.
    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_hold <= n_hold;
        if (w_fire && d_store != 2'd0 && r_tok_len < LB'(6)) begin
            for (int i = 0; i < 6; i++) begin
                if (3'(i) >= w_tl && {1'b0, 3'(i)} < {1'b0, w_tl} + {2'b00, d_store}) begin
                    r_word[i] <= r_win[2'(3'(i) - w_tl)];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/utf8_source_tokenizer.sv
// Top level of the UTF-8 source tokenizer: lexer front end and token queue.
// Takes one source byte per cycle while the lexer is not stalled; a step that ends a token
// without taking its byte holds the input, and no byte is taken while the end item drains.
// A token passes from the window register through the lexing step into the token queue.
// The four-entry token queue lets the lexer run on while the output is stalled.
// Synchronous active-low reset returns line and column to one and the offset to zero.
`default_nettype none

module utf8_source_tokenizer #(
    parameter int OFFSET_BITS   = utf8st_pkg::OFFSET_BITS_DEF,
    parameter int POSITION_BITS = utf8st_pkg::POSITION_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,  // source_byte
    input  wire logic [0:0] i_s_tuser,  // is_end
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    // token_kind, error_kind, start_offset, token_length, token_line, token_column
    output logic [utf8st_pkg::data_bits(OFFSET_BITS, POSITION_BITS)-1:0] o_m_tdata,
    output logic            o_m_tlast   // last_of_run
);

`include "utf8_source_tokenizer_defines.svh"

    localparam int DB = utf8st_pkg::data_bits(OFFSET_BITS, POSITION_BITS);

    logic                    w_push, w_push_last, w_q_full;
    logic [DB-1:0]           w_push_data;
    logic [DB:0]             w_q_out;
    utf8st_pkg::t_front_stat w_stat;

    utf8st_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_end       (i_s_tuser[0]),
        .o_ready     (o_s_tready),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_push_last (w_push_last),
        .o_stat      (w_stat)
    );

    utf8st_tokq #(
        .WIDTH (DB + 1),
        .DEPTH (utf8st_pkg::QUEUE_DEPTH)
    ) u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_last, w_push_data}),
        .o_full  (w_q_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_q_out)
    );

    assign o_m_tdata = w_q_out[DB-1:0];
    assign o_m_tlast = w_q_out[DB];

    `UST_ASSERT_IMP(a_queue_no_overflow, w_push, !w_q_full)
    `UST_ASSERT_IMP(a_no_hold_in_drain, w_stat.hold_valid, !w_stat.draining)
    `UST_ASSERT_IMP(a_end_is_last, o_m_tvalid && o_m_tdata[5:0] == utf8st_pkg::K_END, o_m_tlast)
    `UST_ASSERT_NXT(a_end_starts_drain, i_s_tvalid && o_s_tready && i_s_tuser[0], w_stat.draining)

endmodule

`default_nettype wire

FILE: sim/utf8_source_tokenizer_test.sv
// Self-checking testbench for the UTF-8 source tokenizer, with its own token predictor.
`timescale 1ns / 100ps
`default_nettype none

module utf8_source_tokenizer_test;

    import utf8st_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 400;
    localparam int DATA_W = data_bits(OFFSET_BITS_DEF, POSITION_BITS_DEF);

    typedef struct {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [23:0] off;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] sbyte;
        logic       endf;
        logic       typed;
        token_t     tok;
    } stim_row_t;

    typedef enum logic [2:0] {
        LX_IDLE, LX_IDENT, LX_NUMBER, LX_STRING, LX_CHAR_OPEN, LX_CHAR_ESC, LX_CHAR_BODY
    } lex_mode_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // source_byte
    logic [0:0] i_s_tuser = 1'b0;    // is_end
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    // token_kind, error_kind, start_offset, token_length, token_line, token_column
    logic [DATA_W-1:0] o_m_tdata;
    logic o_m_tlast;                 // last_of_run

    utf8_source_tokenizer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    token_t tokens_due[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit quiet_phase = 0;

    // Lexer state mirrored by the predictor.
    lex_mode_t lx_mode;
    logic [7:0] win [0:2];
    int win_cnt;
    logic [7:0] wbuf [0:5];
    bit esc_flag, dot_flag;
    logic [23:0] tok_start, byte_off;
    logic [15:0] st_line, st_col, cur_line, cur_col;
    int tok_len;
    token_t step_toks [0:3];
    int step_n;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic lex_reset();
        lx_mode = LX_IDLE;
        win_cnt = 0;
        foreach (win[i]) win[i] = 8'h00;
        foreach (wbuf[i]) wbuf[i] = 8'h00;
        esc_flag = 0;
        dot_flag = 0;
        tok_start = '0;
        byte_off = '0;
        st_line = 16'd1;
        st_col = 16'd1;
        cur_line = 16'd1;
        cur_col = 16'd1;
        tok_len = 0;
    endtask

    task automatic push_tok(input logic [5:0] k, input logic [2:0] e, input logic [23:0] o,
                            input int n, input logic [15:0] ln, input logic [15:0] c);
        if (step_n < 4) begin
            step_toks[step_n] = '{k, e, o, 16'(n), ln, c, 1'b0};
            step_n++;
        end
    endtask

    task automatic eat(input int n);
        for (int i = 0; i < n && win_cnt > 0; i++) begin
            if (win[0] == 8'h0A) begin
                cur_line = sat_inc(cur_line);
                cur_col = 16'd1;
            end else begin
                cur_col = sat_inc(cur_col);
            end
            win[0] = win[1];
            win[1] = win[2];
            win_cnt--;
            byte_off = byte_off + 24'd1;
        end
    endtask

    task automatic begin_token();
        tok_start = byte_off;
        st_line = cur_line;
        st_col = cur_col;
        tok_len = 0;
    endtask

    task automatic grow(input int n);
        tok_len = (tok_len + n > 65535) ? 65535 : tok_len + n;
    endtask

    task automatic close_token(input logic [5:0] k, input logic [2:0] e);
        push_tok(k, e, tok_start, tok_len, st_line, st_col);
        lx_mode = LX_IDLE;
    endtask

    function automatic bit cjk_at_head();
        if (win_cnt < 3) return 0;
        if (win[0] < 8'hE4 || win[0] > 8'hE9) return 0;
        if (win[1][7:6] != 2'b10 || win[2][7:6] != 2'b10) return 0;
        return !(win[0] == 8'hE4 && win[1] < 8'hB8);
    endfunction

    function automatic logic [5:0] keyword_of();
        if (tok_len == 3) begin
            case ({wbuf[0], wbuf[1], wbuf[2]})
                24'hE4BBA4: return K_VAR;
                24'hE68192: return K_CONST;
                24'hE587BD: return K_FUNC;
                24'hE8BF94: return K_RETURN;
                24'hE88BA5: return K_IF;
                24'hE4BAA6: return K_ELIF;
                24'hE58899: return K_ELSE;
                24'hE9818D: return K_FOR;
                24'hE5BD93: return K_WHILE;
                24'hE692A4: return K_BREAK;
                24'hE8BF87: return K_CONTINUE;
                24'hE7BB84: return K_STRUCT;
                24'hE59BA2: return K_UNION;
                24'hE79C9F, 24'hE58187: return K_BOOL;
                24'hE7A9BA: return K_NULL;
                default: return K_IDENT;
            endcase
        end
        if (tok_len == 6) begin
            case ({wbuf[0], wbuf[1], wbuf[2], wbuf[3], wbuf[4], wbuf[5]})
                48'hE5AFBCE585A5: return K_IMPORT;
                48'hE5AFBCE587BA: return K_EXPORT;
                default: return K_IDENT;
            endcase
        end
        return K_IDENT;
    endfunction

    task automatic lex_operator();
        logic [5:0] k;
        int n;
        n = 0;
        k = K_ERROR;
        if (win_cnt == 3) begin
            n = 3;
            case ({win[0], win[1], win[2]})
                "...": k = K_ELLIPSIS;
                24'hEFBC81: k = K_NOT;
                24'hEFBC88: k = K_LPAREN;
                24'hEFBC89: k = K_RPAREN;
                24'hEFBC8C: k = K_COMMA;
                24'hEFBC9B: k = K_SEMI;
                24'hEFBC9A: k = K_COLON;
                default: n = 0;
            endcase
        end
        if (n == 0 && win_cnt >= 2) begin
            n = 2;
            case ({win[0], win[1]})
                "**": k = K_POWER;
                "==": k = K_EQ;
                "!=": k = K_NE;
                ">=": k = K_GE;
                "<=": k = K_LE;
                "&&": k = K_AND;
                "||": k = K_OR;
                "+=": k = K_ADD_ASSIGN;
                "-=": k = K_SUB_ASSIGN;
                "*=": k = K_MUL_ASSIGN;
                "/=": k = K_DIV_ASSIGN;
                "%=": k = K_MOD_ASSIGN;
                "=>": k = K_ARROW;
                default: n = 0;
            endcase
        end
        if (n == 0) begin
            n = 1;
            case (win[0])
                "+": k = K_PLUS;
                "-": k = K_MINUS;
                "*": k = K_STAR;
                "/": k = K_SLASH;
                "%": k = K_PERCENT;
                ">": k = K_GT;
                "<": k = K_LT;
                "!": k = K_NOT;
                "=": k = K_ASSIGN;
                "(": k = K_LPAREN;
                ")": k = K_RPAREN;
                "[": k = K_LBRACKET;
                "]": k = K_RBRACKET;
                "{": k = K_LBRACE;
                "}": k = K_RBRACE;
                ",": k = K_COMMA;
                ";": k = K_SEMI;
                ":": k = K_COLON;
                ".": k = K_DOT;
                default: k = K_ERROR;
            endcase
        end
        push_tok(k, (k == K_ERROR) ? E_ILLEGAL : E_NONE, byte_off, n, cur_line, cur_col);
        eat(n);
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (tok_len < 6) wbuf[tok_len] = b;
        grow(1);
    endtask

    task automatic lex_decide();
        logic [7:0] b;
        b = win[0];
        case (lx_mode)
            LX_IDLE: begin
                if (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
                    eat(1);
                end else if (letter(b) || cjk_at_head()) begin
                    begin_token();
                    lx_mode = LX_IDENT;
                end else if (digit(b)) begin
                    begin_token();
                    dot_flag = 0;
                    lx_mode = LX_NUMBER;
                end else if (b == "\"") begin
                    eat(1);
                    begin_token();
                    esc_flag = 0;
                    lx_mode = LX_STRING;
                end else if (b == "'") begin
                    eat(1);
                    begin_token();
                    lx_mode = LX_CHAR_OPEN;
                end else begin
                    lex_operator();
                end
            end
            LX_IDENT: begin
                if (letter(b) || digit(b)) begin
                    keep_byte(b);
                    eat(1);
                end else if (cjk_at_head()) begin
                    keep_byte(win[0]);
                    keep_byte(win[1]);
                    keep_byte(win[2]);
                    eat(3);
                end else begin
                    close_token(keyword_of(), E_NONE);
                end
            end
            LX_NUMBER: begin
                if (digit(b)) begin
                    grow(1);
                    eat(1);
                end else if (b == "." && !dot_flag && win_cnt >= 2 && digit(win[1])) begin
                    dot_flag = 1;
                    grow(1);
                    eat(1);
                end else begin
                    close_token(K_NUMBER, E_NONE);
                end
            end
            LX_STRING: begin
                if (b == "\"" && !esc_flag) begin
                    eat(1);
                    close_token(K_STRING, E_NONE);
                end else begin
                    esc_flag = (b == "\\") ? !esc_flag : 0;
                    grow(1);
                    eat(1);
                end
            end
            LX_CHAR_OPEN, LX_CHAR_ESC: begin
                if (lx_mode == LX_CHAR_OPEN && b == "\\") begin
                    grow(1);
                    eat(1);
                    lx_mode = LX_CHAR_ESC;
                end else if (b == "'") begin
                    close_token(K_ERROR, E_EMPTY_CHAR);
                end else begin
                    grow(1);
                    eat(1);
                    lx_mode = LX_CHAR_BODY;
                end
            end
            LX_CHAR_BODY: begin
                if (b == "'") begin
                    eat(1);
                    close_token(K_CHAR, E_NONE);
                end else begin
                    close_token(K_ERROR, E_LONG_CHAR);
                end
            end
            default: lx_mode = LX_IDLE;
        endcase
    endtask

    // Works out the tokens caused by one accepted transfer.
    task automatic lex_step(input logic [7:0] b, input logic endf);
        step_n = 0;
        if (!endf) begin
            if (win_cnt < 3) begin
                win[win_cnt] = b;
                win_cnt++;
            end
            while (win_cnt == 3) lex_decide();
        end else begin
            while (win_cnt > 0) lex_decide();
            case (lx_mode)
                LX_IDENT: close_token(keyword_of(), E_NONE);
                LX_NUMBER: close_token(K_NUMBER, E_NONE);
                LX_STRING: close_token(K_ERROR, E_OPEN_STR);
                LX_CHAR_OPEN: close_token(K_ERROR, E_OPEN_CHAR);
                LX_CHAR_ESC, LX_CHAR_BODY: close_token(K_ERROR, E_LONG_CHAR);
                default: lx_mode = LX_IDLE;
            endcase
            push_tok(K_END, E_NONE, byte_off, 0, cur_line, cur_col);
            lex_reset();
        end
        if (step_n > 0) step_toks[step_n - 1].last = 1'b1;
    endtask

    // Sender side: one transfer, sometimes with a random gap before it unless in the quiet phase.
    task automatic send_item(input logic [7:0] b, input logic endf);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= endf ? 8'(($urandom_range(0, 255))) : b;
        i_s_tuser <= endf;
        do @(posedge i_clk); while (!o_s_tready);
        lex_step(b, endf);
        for (int i = 0; i < step_n; i++) tokens_due.push_back(step_toks[i]);
    endtask

    task automatic send_row(input stim_row_t row);
        send_item(row.sbyte, row.endf);
        if (row.typed) begin
            void'(tokens_due.pop_back());
            tokens_due.push_back(row.tok);
        end
    endtask

    logic [7:0] src_q[$];

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
    endtask

    task automatic add_cjk(input logic [23:0] w);
        src_q.push_back(w[23:16]);
        src_q.push_back(w[15:8]);
        src_q.push_back(w[7:0]);
    endtask

    task automatic add_random_word();
        logic [23:0] kw [0:15];
        logic [7:0] fw [0:5];
        string ops [0:26];
        kw = '{24'hE4BBA4, 24'hE68192, 24'hE587BD, 24'hE8BF94, 24'hE88BA5, 24'hE4BAA6,
               24'hE58899, 24'hE9818D, 24'hE5BD93, 24'hE692A4, 24'hE8BF87, 24'hE7BB84,
               24'hE59BA2, 24'hE79C9F, 24'hE58187, 24'hE7A9BA};
        fw = '{8'h81, 8'h88, 8'h89, 8'h8C, 8'h9B, 8'h9A};
        ops = '{"==", "!=", "=>", "...", "**=", "+=", "-=", "&&", "||", "%=", "/=", "<=",
                ">=", "(", ")", "[", "]", "{", "}", ",", ";", ":", ".", "-", "<", ">", "!"};
        case ($urandom_range(0, 11))
            0: add_cjk(kw[$urandom_range(0, 15)]);
            1: begin
                add_cjk(24'hE5AFBC);
                add_cjk($urandom_range(0, 1) ? 24'hE585A5 : 24'hE587BA);
            end
            2: begin
                logic [7:0] lead;
                lead = 8'($urandom_range(8'hE4, 8'hE9));
                src_q.push_back(lead);
                src_q.push_back(8'($urandom_range(lead == 8'hE4 ? 8'hB8 : 8'h80, 8'hBF)));
                src_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                if ($urandom_range(0, 1)) add_text("x9");
            end
            3: repeat ($urandom_range(1, 8))
                src_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9"))
                                : 8'($urandom_range("a", "z")));
            4: begin
                repeat ($urandom_range(1, 4)) src_q.push_back(8'($urandom_range("0", "9")));
                case ($urandom_range(0, 3))
                    0: add_text(".5");
                    1: add_text(".");
                    2: add_text("1.2.3");
                    default: ;
                endcase
            end
            5: begin
                add_text("\"");
                repeat ($urandom_range(0, 6)) src_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                if ($urandom_range(0, 1)) add_text("\\\"\\\\");
                add_text("\"");
            end
            6: case ($urandom_range(0, 5))
                0: add_text("'a'");
                1: add_text("'\\n'");
                2: add_text("''");
                3: add_text("'ab'");
                4: add_text("'\\''");
                default: add_text("'\\");
            endcase
            7: begin
                src_q.push_back(8'hEF);
                src_q.push_back(8'hBC);
                src_q.push_back(fw[$urandom_range(0, 5)]);
            end
            8: add_text(ops[$urandom_range(0, 26)]);
            9: src_q.push_back(8'($urandom_range(0, 255)));
            10: add_text($urandom_range(0, 1) ? "\n" : "\t\r");
            default: add_text("_id");
        endcase
        if ($urandom_range(0, 1)) add_text(" ");
    endtask

    stim_row_t directed [0:24];

    initial begin
        int items;
        directed = '{
            '{8'h00, 1'b1, 1'b1, '{K_END, E_NONE, 24'd0, 16'd0, 16'd1, 16'd1, 1'b1}},
            '{8'hFF, 1'b0, 1'b0, '{default: '0}},
            '{8'h20, 1'b0, 1'b0, '{default: '0}},
            '{8'h20, 1'b0, 1'b1, '{K_ERROR, E_ILLEGAL, 24'd0, 16'd1, 16'd1, 16'd1, 1'b1}},
            '{8'h00, 1'b1, 1'b1, '{K_END, E_NONE, 24'd3, 16'd0, 16'd1, 16'd4, 1'b1}},
            '{8'hE5, 1'b0, 1'b0, '{default: '0}},
            '{8'hAF, 1'b0, 1'b0, '{default: '0}},
            '{8'hBC, 1'b0, 1'b0, '{default: '0}},
            '{8'hE5, 1'b0, 1'b0, '{default: '0}},
            '{8'h85, 1'b0, 1'b0, '{default: '0}},
            '{8'hA5, 1'b0, 1'b0, '{default: '0}},
            '{"1", 1'b0, 1'b0, '{default: '0}},
            '{".", 1'b0, 1'b0, '{default: '0}},
            '{".", 1'b0, 1'b0, '{default: '0}},
            '{".", 1'b0, 1'b0, '{default: '0}},
            '{8'h0A, 1'b0, 1'b0, '{default: '0}},
            '{"'", 1'b0, 1'b0, '{default: '0}},
            '{"'", 1'b0, 1'b0, '{default: '0}},
            '{8'h00, 1'b0, 1'b0, '{default: '0}},
            '{8'hEF, 1'b0, 1'b0, '{default: '0}},
            '{8'hBC, 1'b0, 1'b0, '{default: '0}},
            '{8'h81, 1'b0, 1'b0, '{default: '0}},
            '{"=", 1'b0, 1'b0, '{default: '0}},
            '{"\"", 1'b0, 1'b0, '{default: '0}},
            '{8'h00, 1'b1, 1'b0, '{default: '0}}
        };
        lex_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send_row(directed[i]);
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if (items > RANDOM_ITEMS - 60) quiet_phase = 1;
            add_random_word();
            while (src_q.size() > 0) begin
                send_item(src_q.pop_front(), 1'b0);
                items++;
            end
            if ($urandom_range(0, 29) == 0) send_item(8'h00, 1'b1);
        end
        send_item(8'h00, 1'b1);
        i_s_tvalid <= 1'b0;
        while (tokens_due.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver side: checks each token transfer and, outside the quiet phase, stalls in random bursts.
    int stall_left = 0;

    always @(posedge i_clk) begin
        token_t got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[5:0], o_m_tdata[8:6], o_m_tdata[32:9], o_m_tdata[48:33],
                    o_m_tdata[64:49], o_m_tdata[80:65], o_m_tlast};
            if (tokens_due.size() == 0) begin
                fail_count <= fail_count + 1;
                $display("%0t: token with none expected: %p", $time, got);
            end else begin
                want = tokens_due.pop_front();
                if (got != want) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: token mismatch: expected %p, actual %p", $time, want, got);
                end
            end
        end
        if (quiet_phase) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 12);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

endmodule

`default_nettype wire
